// File: src/assert_macros.svh
// Assertion macros used by the decoder engine RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Concurrent assertion of a whole property, sampled on the rising clock edge.
`define RLETD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion of a same-cycle implication.
`define RLETD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define RLETD_ASSERT(lbl, clk, rst_n, prop, msg)
`define RLETD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: src/rletd_pkg.sv
// Types and constants of the run-length table decoder.
package rletd_pkg;

    localparam int unsigned IDX_W     = 24;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_ENTRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_ELEMENTS = 1'd1;

    // Decoder phase: which kind of word is expected next.
    typedef enum logic [2:0] {
        LIT_COUNT,
        LIT_TYPE,
        LIT_VALUE,
        REP_COUNT,
        REP_TYPE,
        REP_VALUE
    } rletd_phase_t;

    typedef struct packed {
        logic [IDX_W-1:0] total_entries;
        logic             pair_elements;
    } rletd_cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] word;
    } rletd_word_t;

    typedef struct packed {
        logic        [IDX_W-1:0]  start_index;
        logic        [IDX_W-1:0]  run_length;
        logic signed [WORD_W-1:0] entry_type;
        logic signed [WORD_W-1:0] entry_value;
        logic                     table_done;
    } rletd_fill_t;

endpackage

// File: src/rletd_stream_if.sv
// Valid/ready stream interface carrying one item of a given payload type.
interface rletd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/rletd_in_stage.sv
// Input register: holds one accepted compressed word until the engine takes it.
module rletd_in_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    rletd_stream_if.sink                   words,
    input  logic                           take,
    output logic                           item_valid,
    output logic [rletd_pkg::WORD_W-1:0]   item_word
);
    logic                         valid_reg;
    logic                         valid_next;
    logic [rletd_pkg::WORD_W-1:0] word_reg;

    // The slot frees up in the same cycle the engine consumes it.
    assign words.ready = !valid_reg || take;
    assign valid_next  = words.valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= words.ready ? valid_next : valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (words.valid && words.ready)
        begin
            word_reg <= $unsigned(words.data.word);
        end
    end

    assign item_valid = valid_reg;
    assign item_word  = word_reg;
endmodule

// File: src/rletd_engine.sv
// Decoder state machine: one word per cycle into fills, unless a fill waits.
`include "assert_macros.svh"

module rletd_engine (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rletd_pkg::rletd_cfg_t        cfg,
    input  logic                         item_valid,
    input  logic [rletd_pkg::WORD_W-1:0] item_word,
    input  logic                         out_free,
    output logic                         take,
    output logic                         load,
    output rletd_pkg::rletd_fill_t       result
);
    localparam int unsigned IW = rletd_pkg::IDX_W;
    localparam int unsigned WW = rletd_pkg::WORD_W;

    rletd_pkg::rletd_phase_t phase_reg;
    rletd_pkg::rletd_phase_t phase_next;
    rletd_pkg::rletd_phase_t phase_eff;
    logic [IW-1:0]           run_left_reg;
    logic [IW-1:0]           run_left_next;
    logic [IW-1:0]           next_index_reg;
    logic [IW-1:0]           next_index_next;
    logic [WW-1:0]           held_type_reg;
    logic [WW-1:0]           held_type_next;
    logic [IW-1:0]           held_count_reg;
    logic [IW-1:0]           held_count_next;

    logic [IW-1:0] rl_eff;
    logic [IW-1:0] ni_eff;
    logic [WW-1:0] ht_eff;
    logic [IW-1:0] hc_eff;
    logic          rearm_now;
    logic          active;
    logic [IW-1:0] room;
    logic [IW-1:0] clip;
    logic [IW-1:0] emit_len;
    logic [IW-1:0] emit_sum;
    logic          emit_done;
    logic [IW-1:0] run_left_dec;
    logic          has_result;
    logic          step;

    // A table that is already full (or whose total was lowered) rearms first.
    assign rearm_now = next_index_reg >= cfg.total_entries;
    assign active    = cfg.total_entries != '0;
    assign phase_eff = rearm_now ? rletd_pkg::LIT_COUNT : phase_reg;
    assign rl_eff    = rearm_now ? '0 : run_left_reg;
    assign ni_eff    = rearm_now ? '0 : next_index_reg;
    assign ht_eff    = rearm_now ? '0 : held_type_reg;
    assign hc_eff    = rearm_now ? '0 : held_count_reg;

    // Counts are unsigned and clipped to the entries left in the table.
    assign room = cfg.total_entries - ni_eff;
    assign clip = (item_word < {{(WW - IW){1'b0}}, room}) ? item_word[IW-1:0] : room;

    assign emit_len     = (phase_eff == rletd_pkg::LIT_VALUE) ? IW'(1) : hc_eff;
    assign emit_sum     = ni_eff + emit_len;
    assign emit_done    = emit_sum >= cfg.total_entries;
    assign run_left_dec = (rl_eff != '0) ? rl_eff - IW'(1) : '0;

    assign has_result = active && ((phase_eff == rletd_pkg::LIT_VALUE)
                        || ((phase_eff == rletd_pkg::REP_VALUE) && (hc_eff != '0)));
    assign take = item_valid && (!has_result || out_free);
    assign load = take && has_result;
    assign step = take && active;

    always_comb
    begin
        result.start_index = ni_eff;
        result.run_length  = emit_len;
        result.entry_type  = $signed(ht_eff);
        result.entry_value = $signed(item_word);
        result.table_done  = emit_done;
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_eff)
                rletd_pkg::LIT_COUNT:
                begin
                    if (clip == '0)
                        phase_next = rletd_pkg::REP_COUNT;
                    else
                        phase_next = cfg.pair_elements ? rletd_pkg::LIT_TYPE
                                                       : rletd_pkg::LIT_VALUE;
                end
                rletd_pkg::LIT_TYPE:
                begin
                    phase_next = rletd_pkg::LIT_VALUE;
                end
                rletd_pkg::LIT_VALUE:
                begin
                    if (emit_done)
                        phase_next = rletd_pkg::LIT_COUNT;
                    else if (run_left_dec == '0)
                        phase_next = rletd_pkg::REP_COUNT;
                    else
                        phase_next = cfg.pair_elements ? rletd_pkg::LIT_TYPE
                                                       : rletd_pkg::LIT_VALUE;
                end
                rletd_pkg::REP_COUNT:
                begin
                    phase_next = cfg.pair_elements ? rletd_pkg::REP_TYPE
                                                   : rletd_pkg::REP_VALUE;
                end
                rletd_pkg::REP_TYPE:
                begin
                    phase_next = rletd_pkg::REP_VALUE;
                end
                rletd_pkg::REP_VALUE:
                begin
                    phase_next = rletd_pkg::LIT_COUNT;
                end
                default:
                begin
                    phase_next = rletd_pkg::LIT_COUNT;
                end
            endcase
        end
    end

    // Counters and held element fields.
    always_comb
    begin
        run_left_next   = run_left_reg;
        next_index_next = next_index_reg;
        held_type_next  = held_type_reg;
        held_count_next = held_count_reg;
        if (step)
        begin
            run_left_next   = rl_eff;
            next_index_next = ni_eff;
            held_type_next  = ht_eff;
            held_count_next = hc_eff;
            unique case (phase_eff)
                rletd_pkg::LIT_COUNT:
                begin
                    run_left_next  = clip;
                    held_type_next = '0;
                end
                rletd_pkg::LIT_TYPE:
                begin
                    held_type_next = item_word;
                end
                rletd_pkg::LIT_VALUE:
                begin
                    held_type_next = '0;
                    if (emit_done)
                    begin
                        run_left_next   = '0;
                        next_index_next = '0;
                        held_count_next = '0;
                    end
                    else
                    begin
                        run_left_next   = run_left_dec;
                        next_index_next = emit_sum;
                    end
                end
                rletd_pkg::REP_COUNT:
                begin
                    held_count_next = clip;
                    held_type_next  = '0;
                end
                rletd_pkg::REP_TYPE:
                begin
                    held_type_next = item_word;
                end
                rletd_pkg::REP_VALUE:
                begin
                    held_type_next = '0;
                    if (hc_eff != '0)
                    begin
                        held_count_next = '0;
                        if (emit_done)
                        begin
                            run_left_next   = '0;
                            next_index_next = '0;
                        end
                        else
                        begin
                            next_index_next = emit_sum;
                        end
                    end
                end
                default:
                begin
                    run_left_next   = '0;
                    next_index_next = '0;
                    held_type_next  = '0;
                    held_count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rletd_pkg::LIT_COUNT;
            run_left_reg   <= '0;
            next_index_reg <= '0;
            held_type_reg  <= '0;
            held_count_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            run_left_reg   <= run_left_next;
            next_index_reg <= next_index_next;
            held_type_reg  <= held_type_next;
            held_count_reg <= held_count_next;
        end
    end

    `RLETD_ASSERT_IMPL(a_load_takes, clk, rst_n, load, take, "result loaded without taking a word")
    `RLETD_ASSERT_IMPL(a_lit_run_left, clk, rst_n,
        (phase_reg == rletd_pkg::LIT_TYPE) || (phase_reg == rletd_pkg::LIT_VALUE),
        run_left_reg != '0, "literal element pending with no elements left")
    `RLETD_ASSERT_IMPL(a_len_nonzero, clk, rst_n, load, result.run_length != '0,
        "fill of zero length")
    `RLETD_ASSERT_IMPL(a_zero_total, clk, rst_n, cfg.total_entries == '0, !load,
        "fill produced with zero total")
    `RLETD_ASSERT(a_done_rearms, clk, rst_n, load && result.table_done |=> next_index_reg == '0,
        "table did not rearm after its last fill")
endmodule

// File: src/rletd_out_stage.sv
// Result register: holds one fill result until the downstream side takes it.
module rletd_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  rletd_pkg::rletd_fill_t result,
    output logic                   out_free,
    rletd_stream_if.source         fills
);
    logic                   valid_reg;
    logic                   valid_next;
    rletd_pkg::rletd_fill_t data_reg;

    assign out_free   = !valid_reg || fills.ready;
    assign valid_next = load || (valid_reg && !fills.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign fills.valid = valid_reg;
    assign fills.data  = data_reg;
endmodule

// File: src/rle_table_decompressor_top.sv
// Top level of the alternating literal/repeat run-length table decoder.
//
// The block takes one 32-bit compressed word per clock cycle, unless a fill
// waits, on the words channel and sends fill results (start index, run length,
// type, value and a table-done flag) on the fills channel. A compressed stream alternates a
// literal run (a count, then that many elements) with a repeat run (a count,
// then one element repeated count times); in pair mode an element is a type
// word followed by a value word. Every completed element that covers at least
// one entry gives one fill. Counts are taken as unsigned and clipped to the
// entries left, and when the fills reach total_entries the result carries
// table_done and the decoder rearms to expect the literal count of the next
// table. A total of zero makes the block consume and discard every word.
//
// Throughput is one word per cycle unless a fill waits: the decoder state
// (phase, elements left, next index, held type and count) is updated in the
// same cycle a word leaves the input register, so consecutive words never
// wait on each other. An accepted word is decoded from the input register; its
// fill enters the result register and is offered on the fills channel. A word
// that yields no fill passes even while a previous fill waits in the result
// register; a word that yields a fill waits only while that register is full
// and not being taken. Configuration is written through cfg_we, cfg_index and
// cfg_data and takes effect at once; it should be changed only while no item
// is in flight.
module rle_table_decompressor_top (
    input  logic                                clk,
    input  logic                                rst_n,
    rletd_stream_if.sink                        words,
    rletd_stream_if.source                      fills,
    input  logic                                cfg_we,
    input  logic [rletd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rletd_pkg::IDX_W-1:0]         cfg_data
);
    logic [rletd_pkg::IDX_W-1:0]   total_entries_reg;
    logic                          pair_elements_reg;
    rletd_pkg::rletd_cfg_t         cfg;

    logic                          item_valid;
    logic [rletd_pkg::WORD_W-1:0]  item_word;
    logic                          take;
    logic                          load;
    logic                          out_free;
    rletd_pkg::rletd_fill_t        result;

    // Configuration registers; writes land directly with no handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_entries_reg <= '0;
            pair_elements_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rletd_pkg::CFG_TOTAL_ENTRIES:
                begin
                    total_entries_reg <= cfg_data;
                end
                rletd_pkg::CFG_PAIR_ELEMENTS:
                begin
                    pair_elements_reg <= cfg_data[0];
                end
                default:
                begin
                    total_entries_reg <= total_entries_reg;
                end
            endcase
        end
    end

    assign cfg.total_entries = total_entries_reg;
    assign cfg.pair_elements = pair_elements_reg;

    // Input register: one word deep, refilled in the cycle it is drained.
    rletd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .take       (take),
        .item_valid (item_valid),
        .item_word  (item_word)
    );

    // Decoder state and the per-word step logic.
    rletd_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_word  (item_word),
        .out_free   (out_free),
        .take       (take),
        .load       (load),
        .result     (result)
    );

    // Result register in front of the fills channel.
    rletd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .result   (result),
        .out_free (out_free),
        .fills    (fills)
    );
endmodule
